// ===== rtl/core/las_pkg.sv =====
`default_nettype none
package las_pkg;

	// APB register map
	localparam int unsigned ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_LIGHT_X,
		REG_LIGHT_Y,
		REG_LIGHT_Z,
		REG_LIGHT_RGB,
		REG_LIGHT_BRIGHT,
		REG_AMB_RGB,
		REG_AMB_BRIGHT,
		REG_FALLOFF
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] light_x;
		logic [31:0] light_y;
		logic [31:0] light_z;
		logic [23:0] light_rgb;
		logic [16:0] light_brightness;
		logic [23:0] ambient_rgb;
		logic [16:0] ambient_brightness;
		logic [31:0] falloff;
	} cfg_t;

	// intermediate values carried down the pipeline
	typedef struct packed {
		logic [63:0]        s;    // sum of squared (shifted) distances
		logic signed [49:0] p;    // normal . distance
		logic               sh;   // distance halved
		logic [31:0]        len;  // floor(sqrt(s))
		logic [16:0]        att;  // attenuation, Q1.16
		logic [20:0]        cos;  // clamped cosine, Q.16
	} item_t;

	// pipeline depths
	localparam int unsigned SQ_STAGES = 16;  // two root bits per stage
	localparam int unsigned AT_STAGES = 9;   // two quotient bits per stage
	localparam int unsigned CD_STAGES = 11;  // two quotient bits per stage
	localparam int unsigned Q_W       = 2 * CD_STAGES;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} sq_t;

	typedef struct packed {
		logic [33:0]    rem;
		logic [Q_W-1:0] num;
		logic [32:0]    dvs;
		logic [Q_W-1:0] quo;
		logic           kill;
	} div_t;

	// one step of the bitwise integer square root
	function automatic sq_t sqrt_step(input sq_t x, input int unsigned j);
		logic [63:0] bit_v;
		logic [63:0] trial;
		sq_t         y;
		bit_v = 64'd1 << (62 - 2 * j);
		trial = x.r + bit_v;
		y = x;
		if (x.v >= trial) begin
			y.v = x.v - trial;
			y.r = (x.r >> 1) + bit_v;
		end else begin
			y.r = x.r >> 1;
		end
		return y;
	endfunction

	// one restoring division step
	function automatic div_t div_step(input div_t x);
		logic [33:0] trial;
		div_t        y;
		trial = {x.rem[32:0], x.num[Q_W-1]};
		y = x;
		y.num = {x.num[Q_W-2:0], 1'b0};
		if (trial >= {1'b0, x.dvs}) begin
			y.rem = trial - {1'b0, x.dvs};
			y.quo = {x.quo[Q_W-2:0], 1'b1};
		end else begin
			y.rem = trial;
			y.quo = {x.quo[Q_W-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/las_if.sv =====
`default_nettype none
interface las_hit_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] hit_x;
	logic signed [31:0] hit_y;
	logic signed [31:0] hit_z;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	modport source (output valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
		input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
		output ready);
endinterface

interface las_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/las_cfg.sv =====
`default_nettype none
module las_cfg
	import las_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write registers, keeping only each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_x            <= '0;
			cfg_q.light_y            <= '0;
			cfg_q.light_z            <= '0;
			cfg_q.light_rgb          <= 24'hFFFFFF;
			cfg_q.light_brightness   <= '0;
			cfg_q.ambient_rgb        <= 24'hFFFFFF;
			cfg_q.ambient_brightness <= '0;
			cfg_q.falloff            <= '0;
		end else if (wr) begin
			case (idx)
				REG_LIGHT_X:      cfg_q.light_x            <= pwdata;
				REG_LIGHT_Y:      cfg_q.light_y            <= pwdata;
				REG_LIGHT_Z:      cfg_q.light_z            <= pwdata;
				REG_LIGHT_RGB:    cfg_q.light_rgb          <= pwdata[23:0];
				REG_LIGHT_BRIGHT: cfg_q.light_brightness   <= pwdata[16:0];
				REG_AMB_RGB:      cfg_q.ambient_rgb        <= pwdata[23:0];
				REG_AMB_BRIGHT:   cfg_q.ambient_brightness <= pwdata[16:0];
				REG_FALLOFF:      cfg_q.falloff            <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_LIGHT_X:      prdata = cfg_q.light_x;
			REG_LIGHT_Y:      prdata = cfg_q.light_y;
			REG_LIGHT_Z:      prdata = cfg_q.light_z;
			REG_LIGHT_RGB:    prdata = {8'd0, cfg_q.light_rgb};
			REG_LIGHT_BRIGHT: prdata = {15'd0, cfg_q.light_brightness};
			REG_AMB_RGB:      prdata = {8'd0, cfg_q.ambient_rgb};
			REG_AMB_BRIGHT:   prdata = {15'd0, cfg_q.ambient_brightness};
			REG_FALLOFF:      prdata = cfg_q.falloff;
			default:          prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/las_geom.sv =====
`default_nettype none
module las_geom
	import las_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire logic [2:0][31:0]  hit_pos,
	input  wire logic [2:0][15:0]  nrm,
	input  cfg_t                   cfg,
	output logic                   out_valid,
	output item_t                  out_item
);
	logic [2:0][31:0] lpos;
	logic [2:0][32:0] d;
	logic [2:0][32:0] mag;
	logic [2:0]       neg;
	logic             big;

	logic             vld_s1, vld_s2, vld_s3;
	logic [2:0][32:0] mag_s1;
	logic [2:0]       neg_s1;
	logic             sh_s1, sh_s2, sh_s3;
	logic [2:0][15:0] nrm_s1;

	logic [2:0][31:0]        a;
	logic signed [32:0]      sa [3];
	logic [63:0]             sq [3];
	logic signed [48:0]      np [3];
	logic [63:0]             sq_s2 [3];
	logic signed [48:0]      np_s2 [3];
	logic [63:0]             s_s3;
	logic signed [49:0]      p_s3;

	assign lpos = {cfg.light_z, cfg.light_y, cfg.light_x};

	// form distance to the light and its magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i]   = {lpos[i][31], lpos[i]} - {hit_pos[i][31], hit_pos[i]};
			neg[i] = d[i][32];
			mag[i] = neg[i] ? (33'd0 - d[i]) : d[i];
		end
		big = (|mag[0][32:31]) | (|mag[1][32:31]) | (|mag[2][32:31]);
	end

	// squares and products with the normal
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i]  = sh_s1 ? mag_s1[i][32:1] : mag_s1[i][31:0];
			sq[i] = a[i] * a[i];
			sa[i] = neg_s1[i] ? -$signed({1'b0, a[i]}) : $signed({1'b0, a[i]});
			np[i] = $signed(nrm_s1[i]) * sa[i];
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag;
			neg_s1 <= neg;
			sh_s1  <= big;
			nrm_s1 <= nrm;
			sh_s2  <= sh_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= sq[i];
				np_s2[i] <= np[i];
			end
			sh_s3 <= sh_s2;
			s_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			p_s3  <= 50'(np_s2[0]) + 50'(np_s2[1]) + 50'(np_s2[2]);
		end
	end

	always_comb begin
		out_item    = '0;
		out_item.s  = s_s3;
		out_item.p  = p_s3;
		out_item.sh = sh_s3;
	end
	assign out_valid = vld_s3;
endmodule
`default_nettype wire

// ===== rtl/core/las_atten.sv =====
`default_nettype none
module las_atten
	import las_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire logic   in_valid,
	input  item_t       in_item,
	input  cfg_t        cfg,
	output logic        out_valid,
	output item_t       out_item
);
	logic [49:0] q;
	logic        vld_s1, vld_s2, vld_s3;
	item_t       itm_s1, itm_s2, itm_s3;
	logic [56:0] mlo_s1, mhi_s1;
	logic [81:0] p_s2;
	logic [48:0] den;
	div_t        dv_init;
	div_t        dv_s3;

	logic        vld_s [AT_STAGES];
	item_t       itm_s [AT_STAGES];
	div_t        dv_s  [AT_STAGES];

	// squared distance in Q.16, undo the halving
	assign q = in_item.sh ? {in_item.s[63:16], 2'b00} : {2'b00, in_item.s[63:16]};

	// set up the divider by one plus falloff times q; an oversized product gives zero
	always_comb begin
		den             = 49'h1_0000 + 49'(p_s2[63:16]);
		dv_init         = '0;
		dv_init.rem     = 34'd16384;
		dv_init.dvs     = den[32:0];
		dv_init.kill    = (|p_s2[81:64]) || (den > 49'h1_0000_0000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			itm_s1 <= in_item;
			mlo_s1 <= cfg.falloff * q[24:0];
			mhi_s1 <= cfg.falloff * q[49:25];
			itm_s2 <= itm_s1;
			p_s2   <= {mhi_s1, 25'd0} + 82'(mlo_s1);
			itm_s3 <= itm_s2;
			dv_s3  <= dv_init;
		end
	end

	// divide 2^32 by the denominator, two quotient bits per stage
	for (genvar k = 0; k < AT_STAGES; k++) begin : g_div
		logic  v_in;
		item_t i_in;
		div_t  d_in;
		if (k == 0) begin : g_first
			assign v_in = vld_s3;
			assign i_in = itm_s3;
			assign d_in = dv_s3;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign i_in = itm_s[k-1];
			assign d_in = dv_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				itm_s[k] <= i_in;
				dv_s[k]  <= div_step(div_step(d_in));
			end
		end
	end

	always_comb begin
		out_item     = itm_s[AT_STAGES-1];
		out_item.att = dv_s[AT_STAGES-1].kill ? 17'd0 : dv_s[AT_STAGES-1].quo[16:0];
	end
	assign out_valid = vld_s[AT_STAGES-1];
endmodule
`default_nettype wire

// ===== rtl/core/las_sqrt.sv =====
`default_nettype none
module las_sqrt
	import las_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire logic   in_valid,
	input  item_t       in_item,
	output logic        out_valid,
	output item_t       out_item
);
	logic  vld_s [SQ_STAGES];
	item_t itm_s [SQ_STAGES];
	sq_t   sq_s  [SQ_STAGES];

	// two root bits per stage, most significant first
	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_root
		logic  v_in;
		item_t i_in;
		sq_t   r_in;
		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign i_in   = in_item;
			assign r_in.v = in_item.s;
			assign r_in.r = '0;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign i_in = itm_s[k-1];
			assign r_in = sq_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				itm_s[k] <= i_in;
				sq_s[k]  <= sqrt_step(sqrt_step(r_in, 2 * k), 2 * k + 1);
			end
		end
	end

	always_comb begin
		out_item     = itm_s[SQ_STAGES-1];
		out_item.len = sq_s[SQ_STAGES-1].r[31:0];
	end
	assign out_valid = vld_s[SQ_STAGES-1];
endmodule
`default_nettype wire

// ===== rtl/core/las_cosdiv.sv =====
`default_nettype none
module las_cosdiv
	import las_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire logic   in_valid,
	input  item_t       in_item,
	output logic        out_valid,
	output item_t       out_item
);
	logic [51:0] num;
	div_t        dv_init;

	logic  vld_s [CD_STAGES];
	item_t itm_s [CD_STAGES];
	div_t  dv_s  [CD_STAGES];

	// set up (4*p) / len; drop the diffuse term when facing away or at the light
	always_comb begin
		num          = {in_item.p[49:0], 2'b00};
		dv_init      = '0;
		dv_init.rem  = 34'(num[51:Q_W]);
		dv_init.num  = num[Q_W-1:0];
		dv_init.dvs  = {1'b0, in_item.len};
		dv_init.kill = in_item.p[49] || (in_item.p == '0) || (in_item.len == '0);
	end

	for (genvar k = 0; k < CD_STAGES; k++) begin : g_div
		logic  v_in;
		item_t i_in;
		div_t  d_in;
		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign i_in = in_item;
			assign d_in = dv_init;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign i_in = itm_s[k-1];
			assign d_in = dv_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				itm_s[k] <= i_in;
				dv_s[k]  <= div_step(div_step(d_in));
			end
		end
	end

	always_comb begin
		out_item     = itm_s[CD_STAGES-1];
		out_item.cos = dv_s[CD_STAGES-1].kill ? 21'd0 : dv_s[CD_STAGES-1].quo[20:0];
	end
	assign out_valid = vld_s[CD_STAGES-1];
endmodule
`default_nettype wire

// ===== rtl/core/las_color.sv =====
`default_nettype none
module las_color
	import las_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic       in_valid,
	input  item_t           in_item,
	input  cfg_t            cfg,
	output logic            out_valid,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);
	logic [2:0][7:0]  lc;
	logic [2:0][7:0]  ac;
	logic [24:0]      amb [3];
	logic [30:0]      lp  [3];
	logic [15:0]      sum [3];

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [37:0]      t_s1;
	logic [38:0]      b_s2;
	logic [2:0][8:0]  amb_s1, amb_s2, amb_s3;
	logic [2:0][14:0] lp_s3;
	logic [2:0][7:0]  rgb_s4;

	assign lc = {cfg.light_rgb[23:16], cfg.light_rgb[15:8], cfg.light_rgb[7:0]};
	assign ac = {cfg.ambient_rgb[23:16], cfg.ambient_rgb[15:8], cfg.ambient_rgb[7:0]};

	// per-channel products, blue at index 0
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amb[i] = ac[i] * cfg.ambient_brightness;
			lp[i]  = lc[i] * b_s2[38:16];
			sum[i] = 16'(lp_s3[i]) + 16'(amb_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// scale cosine by attenuation, then by light ratio, then colour; add ambient and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= in_item.cos * in_item.att;
			for (int i = 0; i < 3; i++) begin
				amb_s1[i] <= amb[i][24:16];
				lp_s3[i]  <= lp[i][30:16];
				rgb_s4[i] <= (sum[i] > 16'd255) ? 8'd255 : sum[i][7:0];
			end
			b_s2   <= t_s1[37:16] * cfg.light_brightness;
			amb_s2 <= amb_s1;
			amb_s3 <= amb_s2;
		end
	end

	assign out_valid = vld_s4;
	assign red       = rgb_s4[2];
	assign green     = rgb_s4[1];
	assign blue      = rgb_s4[0];
endmodule
`default_nettype wire

// ===== rtl/core/lambert_ambient_shade.sv =====
// channel | role    | payload                                 | handshake
// hit     | in      | hit_x/y/z Q16.16, normal_x/y/z Q2.14    | valid/ready
// pix     | out     | red, green, blue 8 bit                  | valid/ready
// apb     | config  | 8 registers at 4*index, 32-bit data     | psel/penable
//
// One item per cycle unless stalled; stages: 3 geometry, 12 attenuation
// (multiply plus 18-bit divider), 16 square root, 11 cosine divider, 4 colour.
// The two dividers and the root retire two bits per stage, which sets depth.
// A full output register with ready low freezes every stage; nothing is lost.
// Reset clears valid bits and loads register defaults.
`default_nettype none
module lambert_ambient_shade
	import las_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	las_hit_if.sink                hit,
	las_rgb_if.source              pix,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);
	cfg_t             cfg;
	logic             adv;
	logic [2:0][31:0] hit_pos;
	logic [2:0][15:0] nrm;
	logic             g_vld, a_vld, r_vld, c_vld, o_vld;
	item_t            g_itm, a_itm, r_itm, c_itm;

	// stall whole pipe only when the result waits
	assign adv       = !o_vld || pix.ready;
	assign hit.ready = adv;
	assign pix.valid = o_vld;
	assign hit_pos   = {hit.hit_z, hit.hit_y, hit.hit_x};
	assign nrm       = {hit.normal_z, hit.normal_y, hit.normal_x};

	las_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	las_geom u_geom (
		.clk, .arst_n, .adv, .in_valid(hit.valid), .hit_pos, .nrm, .cfg,
		.out_valid(g_vld), .out_item(g_itm)
	);

	las_atten u_atten (
		.clk, .arst_n, .adv, .in_valid(g_vld), .in_item(g_itm), .cfg,
		.out_valid(a_vld), .out_item(a_itm)
	);

	las_sqrt u_sqrt (
		.clk, .arst_n, .adv, .in_valid(a_vld), .in_item(a_itm),
		.out_valid(r_vld), .out_item(r_itm)
	);

	las_cosdiv u_cosdiv (
		.clk, .arst_n, .adv, .in_valid(r_vld), .in_item(r_itm),
		.out_valid(c_vld), .out_item(c_itm)
	);

	las_color u_color (
		.clk, .arst_n, .adv, .in_valid(c_vld), .in_item(c_itm), .cfg,
		.out_valid(o_vld), .red(pix.red), .green(pix.green), .blue(pix.blue)
	);
endmodule
`default_nettype wire

// ===== rtl/core/las_checker.sv =====
`default_nettype none
module las_checker
	import las_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hit_ready,
	input  wire logic              pix_valid,
	input  wire logic              pix_ready,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	input  wire logic [31:0]       prdata
);
	// input side is held exactly when a result waits untaken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		hit_ready == (!pix_valid || pix_ready))
		else $error("input ready does not follow output stall");

	// a waiting item keeps its colour
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("stalled item changed");

	// an item leaves only when taken
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pix_valid) |-> $past(pix_ready))
		else $error("item dropped without being taken");

	// light x reads back what was written
	a_rdbk: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_LIGHT_X))
			##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata))
		else $error("light x read back mismatch");
endmodule

bind lambert_ambient_shade las_checker u_las_checker (
	.clk(clk), .arst_n(arst_n), .hit_ready(hit.ready), .pix_valid(pix.valid),
	.pix_ready(pix.ready), .red(pix.red), .green(pix.green), .blue(pix.blue),
	.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
	.pwdata(pwdata), .prdata(prdata)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top
	import las_pkg::*;
();

	typedef struct {
		logic signed [31:0] hx, hy, hz;
		logic signed [15:0] nx, ny, nz;
	} hit_item_t;

	typedef struct {
		logic [7:0] r, g, b;
	} pixel_t;

	// directed row: item plus an optional typed-in pixel
	typedef struct {
		hit_item_t item;
		bit        fixed;
		pixel_t    pix;
	} hit_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	las_hit_if hit_ch();
	las_rgb_if pix_ch();

	lambert_ambient_shade u_top (
		.clk(clk), .arst_n(arst_n), .hit(hit_ch.sink), .pix(pix_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow copy of the register file
	logic [31:0] sh_lx, sh_ly, sh_lz, sh_fall;
	logic [23:0] sh_lrgb, sh_argb;
	logic [16:0] sh_lbr, sh_abr;

	pixel_t shade_q[$];
	int errors;
	int send_idle, recv_idle;

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	initial begin
		#60000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// Lambert plus ambient shading of one hit under the shadow registers
	function automatic pixel_t shade(input hit_item_t it);
		logic signed [32:0] d[3];
		logic [32:0] a[3];
		logic neg[3];
		logic signed [15:0] n[3];
		logic sh;
		logic [63:0] s, len, q, att, c, t, b, den, lc, ac, v;
		logic [127:0] prod;
		logic signed [63:0] p, sa;
		pixel_t o;
		d[0] = $signed(sh_lx) - it.hx;
		d[1] = $signed(sh_ly) - it.hy;
		d[2] = $signed(sh_lz) - it.hz;
		n[0] = it.nx; n[1] = it.ny; n[2] = it.nz;
		sh = 0; s = 0; p = 0; c = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = d[i] < 0;
			a[i] = neg[i] ? -d[i] : d[i];
			if (a[i] >= 33'h80000000) sh = 1;
		end
		for (int i = 0; i < 3; i++) begin
			a[i] = a[i] >> sh;
			s = s + 64'(a[i]) * 64'(a[i]);
			sa = neg[i] ? -$signed(64'(a[i])) : $signed(64'(a[i]));
			p = p + 64'(n[i]) * sa;
		end
		len = root64(s);
		if (len != 0 && p > 0) c = (64'(p) << 2) / len;
		q = (s >> 16) << (2 * sh);
		prod = 128'(sh_fall) * 128'(q);
		if (prod[127:64] != 0) begin
			att = 0;
		end else begin
			den = 65536 + (prod[63:0] >> 16);
			att = (64'd1 << 32) / den;
		end
		t = (c * att) >> 16;
		b = (t * sh_lbr) >> 16;
		for (int i = 0; i < 3; i++) begin
			lc = (sh_lrgb >> (16 - 8 * i)) & 8'hff;
			ac = (sh_argb >> (16 - 8 * i)) & 8'hff;
			v = ((lc * b) >> 16) + ((ac * sh_abr) >> 16);
			if (v > 255) v = 255;
			if (i == 0) o.r = v[7:0];
			else if (i == 1) o.g = v[7:0];
			else o.b = v[7:0];
		end
		return o;
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_LIGHT_X:      sh_lx = val;
			REG_LIGHT_Y:      sh_ly = val;
			REG_LIGHT_Z:      sh_lz = val;
			REG_LIGHT_RGB:    sh_lrgb = val[23:0];
			REG_LIGHT_BRIGHT: sh_lbr = val[16:0];
			REG_AMB_RGB:      sh_argb = val[23:0];
			REG_AMB_BRIGHT:   sh_abr = val[16:0];
			REG_FALLOFF:      sh_fall = val;
			default: ;
		endcase
		// idle between accesses
		@(posedge clk);
	endtask

	// idle with valid low, then hold the item until it is taken
	task automatic send_hit(input hit_item_t it);
		while ($urandom_range(99) < send_idle) begin
			hit_ch.valid <= 1'b0;
			@(posedge clk);
		end
		hit_ch.valid <= 1'b1;
		hit_ch.hit_x <= it.hx; hit_ch.hit_y <= it.hy; hit_ch.hit_z <= it.hz;
		hit_ch.normal_x <= it.nx; hit_ch.normal_y <= it.ny; hit_ch.normal_z <= it.nz;
		do @(posedge clk); while (!hit_ch.ready);
	endtask

	// drop valid, wait for all expected pixels, then let the pipe drain
	task automatic drain();
		hit_ch.valid <= 1'b0;
		while (shade_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic hit_item_t rand_hit(input bit near);
		hit_item_t it;
		if (near) begin
			it.hx = $signed(sh_lx) + $signed(32'($urandom_range(0, 2 ** 22)) - 32'(2 ** 21));
			it.hy = $signed(sh_ly) + $signed(32'($urandom_range(0, 2 ** 22)) - 32'(2 ** 21));
			it.hz = $signed(sh_lz) + $signed(32'($urandom_range(0, 2 ** 22)) - 32'(2 ** 21));
		end else begin
			it.hx = $urandom; it.hy = $urandom; it.hz = $urandom;
		end
		if ($urandom_range(9) == 0) begin
			it.nx = $urandom; it.ny = $urandom; it.nz = $urandom;
		end else begin
			it.nx = $urandom_range(0, 32768) - 16384;
			it.ny = $urandom_range(0, 32768) - 16384;
			it.nz = $urandom_range(0, 32768) - 16384;
		end
		return it;
	endfunction

	// accept pixels and compare with the oldest prediction
	always @(posedge clk) begin
		pixel_t e;
		if (pix_ch.valid && pix_ch.ready) begin
			if (shade_q.size() == 0) begin
				$display("%0t: pixel %h %h %h with none expected", $time,
					pix_ch.red, pix_ch.green, pix_ch.blue);
				errors++;
			end else begin
				e = shade_q.pop_front();
				if (e.r !== pix_ch.red) begin
					$display("%0t: red expected %h actual %h", $time, e.r, pix_ch.red);
					errors++;
				end
				if (e.g !== pix_ch.green) begin
					$display("%0t: green expected %h actual %h", $time, e.g, pix_ch.green);
					errors++;
				end
				if (e.b !== pix_ch.blue) begin
					$display("%0t: blue expected %h actual %h", $time, e.b, pix_ch.blue);
					errors++;
				end
			end
		end
		pix_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		hit_row_t rows[$];
		hit_row_t rw;
		errors = 0;
		send_idle = 8; recv_idle = 61;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		hit_ch.valid = 0;
		hit_ch.hit_x = 0; hit_ch.hit_y = 0; hit_ch.hit_z = 0;
		hit_ch.normal_x = 0; hit_ch.normal_y = 0; hit_ch.normal_z = 0;
		pix_ch.ready = 0;
		sh_lx = 0; sh_ly = 0; sh_lz = 0; sh_lrgb = 24'hffffff; sh_lbr = 0;
		sh_argb = 24'hffffff; sh_abr = 0; sh_fall = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: both ratios zero, so black
		rw.item = '{32'sd0, 32'sd0, -32'sd65536, 16'sd0, 16'sd0, 16'sd16384};
		rw.fixed = 1; rw.pix = '{8'd0, 8'd0, 8'd0};
		rows.push_back(rw);
		foreach (rows[i]) begin
			shade_q.push_back(rows[i].fixed ? rows[i].pix : shade(rows[i].item));
			send_hit(rows[i].item);
		end
		drain();

		// full ambient and light, no falloff
		reg_write(REG_AMB_BRIGHT, 32'h10000);
		reg_write(REG_LIGHT_BRIGHT, 32'h10000);
		reg_write(REG_AMB_RGB, 32'h102030);
		reg_write(REG_LIGHT_RGB, 32'hff8040);
		reg_write(REG_LIGHT_Z, 32'h00040000);
		rows.delete();
		// light at the hit point: ambient only
		rw.item = '{32'sd0, 32'sd0, 32'sh40000, 16'sd0, 16'sd0, 16'sd16384};
		rw.fixed = 1; rw.pix = '{8'h10, 8'h20, 8'h30}; rows.push_back(rw);
		// light behind the surface: ambient only
		rw.item = '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, -16'sd16384};
		rows.push_back(rw);
		// head-on, unit cosine
		rw.item = '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd16384};
		rw.fixed = 0; rows.push_back(rw);
		// extremes of position and normal
		rw.item = '{32'h80000000, 32'h7fffffff, 32'h80000000, 16'sd16384, -16'sd16384, 16'sd16384};
		rows.push_back(rw);
		rw.item = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, -16'sd16384, 16'sd16384, -16'sd16384};
		rows.push_back(rw);
		// oversized normal: cosine above one saturates
		rw.item = '{32'sd0, 32'sd0, 32'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff};
		rows.push_back(rw);
		rw.item = '{32'sd65536, -32'sd65536, 32'sd0, 16'sh8000, 16'sh8000, 16'sh8000};
		rows.push_back(rw);
		foreach (rows[i]) begin
			shade_q.push_back(rows[i].fixed ? rows[i].pix : shade(rows[i].item));
			send_hit(rows[i].item);
		end
		drain();

		// random phases across register settings
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin send_idle = 61; recv_idle = 8; end
			if (ph == 8) begin send_idle = 0; recv_idle = 0; end
			case (ph % 4)
				0: begin
					reg_write(REG_FALLOFF, 32'hffffffff);
					reg_write(REG_LIGHT_BRIGHT, 32'h1ffff);
					reg_write(REG_AMB_BRIGHT, 32'h0);
				end
				1: begin
					reg_write(REG_FALLOFF, 32'h0);
					reg_write(REG_LIGHT_BRIGHT, 32'h0);
					reg_write(REG_AMB_BRIGHT, 32'h1ffff);
				end
				default: begin
					reg_write(REG_FALLOFF, $urandom_range(0, 32'h4000));
					reg_write(REG_LIGHT_BRIGHT, $urandom_range(0, 32'h1ffff));
					reg_write(REG_AMB_BRIGHT, $urandom_range(0, 32'h8000));
				end
			endcase
			reg_write(REG_LIGHT_X, $urandom);
			reg_write(REG_LIGHT_Y, $urandom);
			reg_write(REG_LIGHT_Z, $urandom);
			reg_write(REG_LIGHT_RGB, $urandom);
			reg_write(REG_AMB_RGB, $urandom);
			for (int k = 0; k < 70; k++) begin
				hit_item_t it;
				it = rand_hit($urandom_range(3) != 0);
				shade_q.push_back(shade(it));
				send_hit(it);
			end
			drain();
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
